FILE: rtl/slwm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slwm_pkg;

    localparam int CFG_W = 9;

    typedef struct packed {
        logic accept;
        logic pop_front;
        logic rd_tail;
        logic pop_back;
        logic push;
        logic load_out;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic expire;
        logic drop;
        logic window_full;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/slwm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module slwm_ctrl
    import slwm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic       i_cfg_valid,
    input  wire t_dp_status i_status,
    output logic            o_in_ready,
    output logic            o_cfg_ready,
    output t_dp_cmd         o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_RES
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !i_cfg_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_HEAD;
                end
            end
            S_HEAD: begin
                o_cmd.pop_front = i_status.expire;
                o_cmd.rd_tail   = 1'b1;
                n_state         = S_TAIL;
            end
            S_TAIL: begin
                if (i_status.drop) begin
                    o_cmd.pop_back = 1'b1;
                    o_cmd.rd_tail  = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state    = S_RES;
                end
            end
            S_RES: begin
                if (!i_status.window_full) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.finish   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/slwm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module slwm_datapath
    import slwm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    input  wire logic                   i_eos,
    input  wire t_dp_cmd                i_cmd,
    output t_dp_status                  o_status,
    input  wire logic                   i_out_ready,
    output logic                        o_out_valid,
    output logic [SAMPLE_BITS-1:0]      o_out_max,
    output logic                        o_out_last
);

    localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNTW = $clog2(WINDOW_DEPTH + 1);
    localparam int CMPW = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int EW   = SAMPLE_BITS + AW;
    localparam logic [AW-1:0] LAST_IDX = AW'(WINDOW_DEPTH - 1);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] x);
        f_inc = (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] x);
        f_dec = (x == '0) ? LAST_IDX : x - 1'b1;
    endfunction

    // Each queue entry holds a candidate value and its ring position.
    logic [EW-1:0]          r_mem [WINDOW_DEPTH];
    logic [EW-1:0]          r_rdata;

    logic [AW-1:0]          r_head, n_head;
    logic [AW-1:0]          r_tail, n_tail;
    logic [CNTW-1:0]        r_cnt, n_cnt;
    logic [AW-1:0]          r_wp, n_wp;
    logic [CNTW-1:0]        r_fill, n_fill;
    logic [CFG_W-1:0]       r_win, n_win;
    logic [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic                   r_eos, n_eos;
    logic                   r_was_empty, n_was_empty;
    logic                   r_out_valid, n_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_max, n_out_max;
    logic                   r_out_last, n_out_last;

    logic [CMPW-1:0]        w_eff;
    logic [AW:0]            age;
    logic [SAMPLE_BITS-1:0] rd_val;
    logic [AW-1:0]          rd_pos;
    logic                   rd_en;
    logic [AW-1:0]          rd_addr;

    assign rd_val = r_rdata[EW-1:AW];
    assign rd_pos = r_rdata[AW-1:0];

    always_comb begin
        if (r_win == '0) begin
            w_eff = CMPW'(1);
        end else if (CMPW'(r_win) > CMPW'(WINDOW_DEPTH)) begin
            w_eff = CMPW'(WINDOW_DEPTH);
        end else begin
            w_eff = CMPW'(r_win);
        end
    end

    always_comb begin
        if (r_wp > rd_pos) begin
            age = {1'b0, r_wp} - {1'b0, rd_pos};
        end else begin
            age = {1'b0, r_wp} + (AW + 1)'(WINDOW_DEPTH) - {1'b0, rd_pos};
        end
    end

    assign o_status.expire      = (r_cnt != '0) && (CMPW'(age) >= w_eff);
    assign o_status.drop        = (r_cnt != '0) && (rd_val <= r_sample);
    assign o_status.window_full = (CMPW'(r_fill) >= w_eff);
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_wp        = r_wp;
        n_fill      = r_fill;
        n_win       = r_win;
        n_sample    = r_sample;
        n_eos       = r_eos;
        n_was_empty = r_was_empty;
        n_out_valid = r_out_valid;
        n_out_max   = r_out_max;
        n_out_last  = r_out_last;

        if (i_cmd.accept) begin
            n_sample = i_sample;
            n_eos    = i_eos;
        end
        if (i_cmd.pop_front) begin
            n_head = f_inc(r_head);
            n_cnt  = r_cnt - 1'b1;
        end
        if (i_cmd.pop_back) begin
            n_tail = f_dec(r_tail);
            n_cnt  = r_cnt - 1'b1;
        end
        if (i_cmd.push) begin
            n_tail      = f_inc(r_tail);
            n_cnt       = r_cnt + 1'b1;
            n_wp        = f_inc(r_wp);
            n_was_empty = (r_cnt == '0);
            if (CMPW'(r_fill) < w_eff) begin
                n_fill = r_fill + 1'b1;
            end
        end

        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
            n_out_max   = r_was_empty ? r_sample : rd_val;
            n_out_last  = r_eos;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if ((i_cmd.finish && r_eos) || i_cfg_we) begin
            n_head = '0;
            n_tail = '0;
            n_cnt  = '0;
            n_wp   = '0;
            n_fill = '0;
        end
        if (i_cfg_we) begin
            n_win = i_cfg_data;
        end
    end

    assign rd_en   = i_cmd.accept || i_cmd.rd_tail || i_cmd.push;
    assign rd_addr = i_cmd.rd_tail ? f_dec(n_tail) : r_head;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= {r_sample, r_wp};
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_eos       <= n_eos;
        r_was_empty <= n_was_empty;
        r_out_max   <= n_out_max;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_cnt       <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_win       <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_cnt       <= n_cnt;
            r_wp        <= n_wp;
            r_fill      <= n_fill;
            r_win       <= n_win;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_max   = r_out_max;
    assign o_out_last  = r_out_last;

endmodule

`default_nettype wire

FILE: rtl/sliding_window_max.sv
// Running maximum over the most recent window_size samples of a stream.
// Samples enter on the s_axis channel: the sample sits in the low bits of
// s_axis_tdata and s_axis_tlast marks the final sample of a stream. For
// every sample, once window_size samples of the current stream have
// arrived, one result leaves on the m_axis channel with the maximum in
// m_axis_tdata and m_axis_tlast set on the result of the final sample.
// A stream that ends before the window fills gives no result.
// The window length is written through the cfg channel while the block is
// idle; a write starts a fresh stream. Zero counts as one and values above
// WINDOW_DEPTH count as WINDOW_DEPTH.
// A transaction steps through the head, tail and result states; the tail
// state repeats once for each older candidate that the new sample displaces
// from the back of the candidate queue, one queue memory access at a time.
// On average a sample displaces at most one candidate. The result is loaded
// into the output register in the result state.
// Reset clears the stream state and sets the window length to one. A
// stalled receiver holds its result in the output register; the next
// input transaction is still taken, and its result waits for that register.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_max
    import slwm_pkg::*;
#(
    parameter int WINDOW_DEPTH = 256,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [CFG_W-1:0]                     i_cfg_data,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // sample
    input  wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0] s_axis_tdata,
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // window_max
    output logic [((SAMPLE_BITS + 7) / 8)*8-1:0]      m_axis_tdata,
    output logic                                      m_axis_tlast
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    t_dp_cmd                w_cmd;
    t_dp_status             w_status;
    logic [SAMPLE_BITS-1:0] w_out_max;

    slwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (w_status),
        .o_in_ready  (s_axis_tready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (w_cmd)
    );

    slwm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata[SAMPLE_BITS-1:0]),
        .i_eos       (s_axis_tlast),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_max   (w_out_max),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_W'(w_out_max);

endmodule

`default_nettype wire

FILE: rtl/slwm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module slwm_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                                 i_clk,
    input wire logic                                 i_rst_n,
    input wire logic                                 s_axis_tvalid,
    input wire logic                                 s_axis_tready,
    input wire logic                                 m_axis_tvalid,
    input wire logic                                 m_axis_tready,
    input wire logic [((SAMPLE_BITS + 7) / 8)*8-1:0] m_axis_tdata,
    input wire logic                                 m_axis_tlast
);

    a_out_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result withdrawn before its transaction completed.");

    a_out_data_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("Result changed while stalled.");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("Input taken again while a sample was in progress.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("Result appeared without a sample being processed.");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result valid straight after reset.");

endmodule

bind sliding_window_max slwm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_slwm_checker (.*);

`default_nettype wire

FILE: test/tb_sliding_window_max.sv
`timescale 1ns / 1ps

module tb_sliding_window_max;
    import slwm_pkg::*;

    localparam int WINDOW_DEPTH  = 256;
    localparam int SAMPLE_BITS   = 16;
    localparam int DATA_W        = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int TOTAL_SAMPLES = 1800;
    localparam int SHOWN_ERRORS  = 10;

    typedef enum int {SENDER_LIGHT, RECEIVER_LIGHT, NO_GAPS} t_idle_mode;
    typedef enum int {ANY_VALUE, NARROW, EXTREMES, FALLING, RISING} t_sample_shape;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] window_max;
        logic                   last_result;
    } t_max_result;

    class WindowMaxScoreboard;
        int unsigned            window_len = 1;
        logic [SAMPLE_BITS-1:0] window_samples[$];
        t_max_result            pending_max[$];
        int                     mismatches = 0;
        int                     maxima_checked = 0;
        int                     streams_closed = 0;

        function void set_window(logic [CFG_W-1:0] value);
            if (value == 0) begin
                window_len = 1;
            end else if (value > WINDOW_DEPTH) begin
                window_len = WINDOW_DEPTH;
            end else begin
                window_len = 32'(value);
            end
            window_samples.delete();
        endfunction

        function void note_sample(logic [SAMPLE_BITS-1:0] sample, logic end_of_stream);
            t_max_result            expected;
            logic [SAMPLE_BITS-1:0] peak;
            window_samples.push_back(sample);
            if (window_samples.size() > window_len) begin
                void'(window_samples.pop_front());
            end
            if (window_samples.size() == window_len) begin
                peak = '0;
                foreach (window_samples[i]) begin
                    if (window_samples[i] > peak) begin
                        peak = window_samples[i];
                    end
                end
                expected.window_max  = peak;
                expected.last_result = end_of_stream;
                pending_max.push_back(expected);
            end
            if (end_of_stream) begin
                window_samples.delete();
                streams_closed++;
            end
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("%s", what);
            end
        endfunction

        function void check_max(logic [SAMPLE_BITS-1:0] window_max, logic last_result);
            t_max_result expected;
            maxima_checked++;
            if (pending_max.size() == 0) begin
                flag($sformatf("Unexpected result: max %0d last %0b", window_max, last_result));
            end else begin
                expected = pending_max.pop_front();
                if (window_max !== expected.window_max) begin
                    flag($sformatf("Window max mismatch: expected %0d, got %0d",
                                   expected.window_max, window_max));
                end
                if (last_result !== expected.last_result) begin
                    flag($sformatf("Last mark mismatch: expected %0b, got %0b",
                                   expected.last_result, last_result));
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [DATA_W-1:0]      s_axis_tdata;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [DATA_W-1:0]      m_axis_tdata;
    logic                   m_axis_tlast;

    WindowMaxScoreboard     sb;
    t_idle_mode             idle_mode = SENDER_LIGHT;
    int                     samples_sent = 0;
    int                     windows_programmed = 0;
    int                     cycle_count = 0;

    sliding_window_max #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d results outstanding.", sb.pending_max.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            case (idle_mode)
                SENDER_LIGHT: begin
                    m_axis_tready <= ($urandom_range(0, 99) >= 75);
                end
                RECEIVER_LIGHT: begin
                    m_axis_tready <= ($urandom_range(0, 99) >= 20);
                end
                default: begin
                    m_axis_tready <= 1'b1;
                end
            endcase
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                sb.check_max(m_axis_tdata[SAMPLE_BITS-1:0], m_axis_tlast);
            end
        end
    end

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(t_sample_shape shape,
                                                           logic [SAMPLE_BITS-1:0] base,
                                                           int unsigned idx);
        case (shape)
            NARROW:   return SAMPLE_BITS'($urandom_range(0, 3));
            EXTREMES: return $urandom_range(0, 1) ? '1 : '0;
            FALLING:  return SAMPLE_BITS'(base - idx);
            RISING:   return SAMPLE_BITS'(base + idx);
            default:  return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample, input logic end_of_stream);
        int unsigned gap_pct;
        case (idle_mode)
            SENDER_LIGHT:   gap_pct = 20;
            RECEIVER_LIGHT: gap_pct = 75;
            default:        gap_pct = 0;
        endcase
        while ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DATA_W'(sample);
        s_axis_tlast  <= end_of_stream;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        sb.note_sample(sample, end_of_stream);
        samples_sent++;
        if (samples_sent >= 2 * TOTAL_SAMPLES / 3) begin
            idle_mode = NO_GAPS;
        end else if (samples_sent >= TOTAL_SAMPLES / 3) begin
            idle_mode = RECEIVER_LIGHT;
        end
    endtask

    // The block may still be working on a sample that gives no result, so
    // the write waits out the longest displacement run as well.
    task automatic program_window(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_max.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        sb.set_window(value);
        windows_programmed++;
    endtask

    task automatic run_window_phase(input logic [CFG_W-1:0] value);
        int unsigned            span;
        int unsigned            budget;
        int unsigned            len;
        int unsigned            idx;
        t_sample_shape          shape;
        logic [SAMPLE_BITS-1:0] base;
        program_window(value);
        span   = sb.window_len;
        budget = (span >= 64) ? span + 40 : 100;
        while (budget > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                len = $urandom_range(1, span);
            end else begin
                len = span + $urandom_range(0, (span < 64) ? 2 * span + 8 : 40);
            end
            shape = t_sample_shape'($urandom_range(0, 4));
            base  = SAMPLE_BITS'($urandom);
            for (idx = 0; idx < len && budget > 0; idx++) begin
                send_sample(pick_sample(shape, base, idx), idx == len - 1);
                budget--;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] fixed_windows[6];
        fixed_windows = '{9'd256, 9'd1, 9'd511, 9'd0, 9'd2, 9'd3};
        sb            = new;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of one, with both sample extremes.
        send_sample(16'd0, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        // A zero length behaves as one.
        program_window(9'd0);
        send_sample(16'd12345, 1'b1);
        // Equal samples, a peak leaving the window and a closing result.
        program_window(9'd3);
        send_sample(16'd5, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd5, 1'b0);
        send_sample(16'd1, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b1);
        // A stream that ends before the window fills.
        send_sample(16'd7, 1'b0);
        send_sample(16'd8, 1'b1);
        // A new length written in the middle of a stream starts a fresh one.
        send_sample(16'd9, 1'b0);
        send_sample(16'd10, 1'b0);
        program_window(9'd2);
        send_sample(16'd4, 1'b0);
        send_sample(16'd3, 1'b1);
        // An oversized length is clamped to the largest window.
        program_window(9'h1FF);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd1, 1'b1);

        foreach (fixed_windows[i]) begin
            run_window_phase(fixed_windows[i]);
        end
        while (samples_sent < TOTAL_SAMPLES) begin
            if ($urandom_range(0, 4) == 0) begin
                run_window_phase(CFG_W'($urandom_range(41, 511)));
            end else begin
                run_window_phase(CFG_W'($urandom_range(1, 40)));
            end
        end

        s_axis_tvalid <= 1'b0;
        while (sb.pending_max.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d samples under %0d window lengths, zero and oversized ones included.",
                 samples_sent, windows_programmed);
        $display("Checked %0d window maxima over %0d closed streams with both sides stalling.",
                 sb.maxima_checked, sb.streams_closed);
        if (sb.mismatches == 0 && sb.pending_max.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatches: %0d, results never seen: %0d",
                     sb.mismatches, sb.pending_max.size());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: sliding_window_max.f
rtl/slwm_pkg.sv
rtl/slwm_ctrl.sv
rtl/slwm_datapath.sv
rtl/sliding_window_max.sv
rtl/slwm_checker.sv
test/tb_sliding_window_max.sv
